// ===== sv/nearest_point_search_3d_assert.svh =====
// assertion macros for the nearest point search checker
// expects signals named clk and rst_n in the scope of use
`ifndef NEAREST_POINT_SEARCH_3D_ASSERT_SVH
`define NEAREST_POINT_SEARCH_3D_ASSERT_SVH

// property checked on every clock edge outside reset
`define NPS3D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the edge after the trigger
`define NPS3D_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/nps3d_pkg.sv =====
// shared types and constants for the nearest point search block
// no dependencies
`default_nettype none

package nps3d_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = SQ_W + 2;
    localparam int POINT_W    = 3 * COORD_BITS;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
    } scan_tag_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/nps3d_item_if.sv =====
// input channel: action and one point per transaction
// depends on nps3d_pkg
`default_nettype none

interface nps3d_item_if
    import nps3d_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    coord_t           coord_x;
    coord_t           coord_y;
    coord_t           coord_z;

    modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
    modport sink (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// ===== sv/nps3d_result_if.sv =====
// result channel: nearest index and squared distance per transaction
// depends on nps3d_pkg
`default_nettype none

interface nps3d_result_if
    import nps3d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] distance_squared;

    modport source (output valid, found, nearest_index, distance_squared, input ready);
    modport sink (input valid, found, nearest_index, distance_squared, output ready);
endinterface

`default_nettype wire

// ===== sv/nps3d_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module nps3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/nps3d_dist.sv =====
// three-stage squared distance unit: difference, square, sum
// depends on nps3d_pkg; a scan tag rides along with each point
`default_nettype none

module nps3d_dist
    import nps3d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire scan_tag_t   tag_in,
    input  wire point_t      src,
    input  wire point_t      tgt,
    output scan_tag_t        tag_out,
    output logic [DIST_W-1:0] dist_sq
);

    scan_tag_t                tag_d_reg;
    scan_tag_t                tag_s_reg;
    scan_tag_t                tag_o_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dz_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [DIFF_W-1:0] dz_next;
    logic signed [2*DIFF_W-1:0] px;
    logic signed [2*DIFF_W-1:0] py;
    logic signed [2*DIFF_W-1:0] pz;
    logic [SQ_W-1:0]          sx_reg;
    logic [SQ_W-1:0]          sy_reg;
    logic [SQ_W-1:0]          sz_reg;
    logic [DIST_W-1:0]        sum_reg;
    logic [DIST_W-1:0]        sum_next;

    always_comb
    begin
        dx_next  = {src.x[COORD_BITS-1], src.x} - {tgt.x[COORD_BITS-1], tgt.x};
        dy_next  = {src.y[COORD_BITS-1], src.y} - {tgt.y[COORD_BITS-1], tgt.y};
        dz_next  = {src.z[COORD_BITS-1], src.z} - {tgt.z[COORD_BITS-1], tgt.z};
        px       = dx_reg * dx_reg;
        py       = dy_reg * dy_reg;
        pz       = dz_reg * dz_reg;
        sum_next = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg <= '0;
            tag_s_reg <= '0;
            tag_o_reg <= '0;
        end
        else
        begin
            tag_d_reg <= tag_in;
            tag_s_reg <= tag_d_reg;
            tag_o_reg <= tag_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        sx_reg  <= px[SQ_W-1:0];
        sy_reg  <= py[SQ_W-1:0];
        sz_reg  <= pz[SQ_W-1:0];
        sum_reg <= sum_next;
    end

    assign tag_out = tag_o_reg;
    assign dist_sq = sum_reg;

endmodule

`default_nettype wire

// ===== sv/nearest_point_search_3d.sv =====
// brute-force nearest point search over a table of up to 1024 3d points
// clear and load update the point count when accepted; a query over n points
// streams one point per cycle through the distance unit; result valid and input
// ready rise after the last compare or empty-table query, later if a result waits
// reset clears the point count and the sequencer; table content stays undefined
// depends on nps3d_pkg, nps3d_item_if, nps3d_result_if, nps3d_ram, nps3d_dist
`default_nettype none

module nearest_point_search_3d
    import nps3d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    nps3d_item_if.sink      item,
    nps3d_result_if.source  result
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    scan_tag_t         tag_rd_reg, tag_rd_next;
    point_t            src_reg, src_next;
    logic              best_found_reg, best_found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;

    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [POINT_W-1:0] ram_rdata;
    point_t            in_point;
    scan_tag_t         tag_cmp;
    logic [DIST_W-1:0] dist_cmp;
    logic              out_free;

    assign in_point = '{x: item.coord_x, y: item.coord_y, z: item.coord_z};
    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign ram_we   = accept && (action_t'(item.action) == ACT_LOAD)
                      && (cnt_reg < CNT_W'(MAX_POINTS));
    assign ram_re   = (state_reg == ST_SCAN);

    nps3d_ram #(
        .WIDTH(POINT_W),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (in_point),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    nps3d_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_rd_reg),
        .src     (src_reg),
        .tgt     (point_t'(ram_rdata)),
        .tag_out (tag_cmp),
        .dist_sq (dist_cmp)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        tag_rd_next     = '0;
        src_next        = src_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_found_next  = out_found_reg;
        out_idx_next    = out_idx_reg;
        out_dist_next   = out_dist_reg;

        if (tag_cmp.valid && ((tag_cmp.index == '0) || (dist_cmp < best_dist_reg)))
        begin
            best_dist_next = dist_cmp;
            best_idx_next  = tag_cmp.index;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(item.action))
                        ACT_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        ACT_LOAD:
                        begin
                            if (ram_we)
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_QUERY:
                        begin
                            src_next        = in_point;
                            issue_next      = '0;
                            best_found_next = (cnt_reg != '0);
                            best_idx_next   = '0;
                            best_dist_next  = '0;
                            state_next      = (cnt_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                tag_rd_next.valid = 1'b1;
                tag_rd_next.index = issue_reg[IDX_W-1:0];
                tag_rd_next.last  = (issue_reg == cnt_reg - CNT_W'(1));
                issue_next        = issue_reg + CNT_W'(1);
                if (tag_rd_next.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tag_cmp.valid && tag_cmp.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = best_found_reg;
                    out_idx_next   = best_idx_reg;
                    out_dist_next  = best_dist_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tag_rd_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tag_rd_reg    <= tag_rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        src_reg        <= src_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        out_found_reg  <= out_found_next;
        out_idx_reg    <= out_idx_next;
        out_dist_reg   <= out_dist_next;
    end

    assign item.ready              = (state_reg == ST_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.found            = out_found_reg;
    assign result.nearest_index    = out_idx_reg;
    assign result.distance_squared = out_dist_reg;

endmodule

`default_nettype wire

// ===== sv/nps3d_checker.sv =====
// port-level checker for nearest_point_search_3d, bound to the top level
// depends on nps3d_pkg and nearest_point_search_3d_assert.svh
`default_nettype none

`include "nearest_point_search_3d_assert.svh"

module nps3d_checker
    import nps3d_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire logic [ACT_W-1:0]  item_action,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic              result_found,
    input wire logic [IDX_W-1:0]  result_index,
    input wire logic [DIST_W-1:0] result_dist
);

    logic query_acc;

    assign query_acc = item_valid && item_ready && (action_t'(item_action) == ACT_QUERY);

    `NPS3D_ASSERT(a_empty_result_zero,
        !(result_valid && !result_found) || (result_index == '0 && result_dist == '0),
        "empty-table result carries nonzero payload")

    `NPS3D_ASSERT_NEXT(a_busy_after_query, query_acc, !item_ready,
        "block ready right after a query transaction")

    `NPS3D_ASSERT_NEXT(a_no_early_result, query_acc && !result_valid, !result_valid,
        "result appeared one cycle after a query")

    `NPS3D_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_found) && $stable(result_index)
        && $stable(result_dist),
        "stalled result dropped or changed")

endmodule

bind nearest_point_search_3d nps3d_checker u_nps3d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_action  (item.action),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_found (result.found),
    .result_index (result.nearest_index),
    .result_dist  (result.distance_squared)
);

`default_nettype wire
